/* hw/rtl/lfa_pkg.sv */
// lfa_pkg: shared types and codes of the lifo arena allocator
// used by lfa_rec_stack and lifo_arena_allocator, no dependencies
package lfa_pkg;

  localparam int unsigned ADDR_W     = 24;  // arena offsets and capacity
  localparam int unsigned TOTAL_W    = 32;  // saturating byte counters
  localparam int unsigned REC_SIZE_W = 25;  // aligned size may pass 24 bits

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_GROW  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STACK_FULL  = 3'd1,
    ST_FREE_EMPTY  = 3'd2,
    ST_MISMATCH    = 3'd3,
    ST_GROW_IN_USE = 3'd4
  } status_t;

  typedef struct packed {
    logic                  heap;
    logic [REC_SIZE_W-1:0] size;
  } record_t;

  typedef struct packed {
    logic    push;
    logic    pop;
    record_t rec;
  } stack_ctrl_t;

endpackage

/* hw/rtl/lfa_rec_stack.sv */
// lfa_rec_stack: record stack of block sizes and fallback flags
// top entry held in a register, the rest in a memory; uses lfa_pkg
module lfa_rec_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lfa_pkg::stack_ctrl_t         ctrl,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  output lfa_pkg::record_t             top
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lfa_pkg::record_t  mem [DEPTH];
  lfa_pkg::record_t  top_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  below_top;

  assign wr_idx    = count_r[IDX_W-1:0];
  // entry that becomes the top after a pop
  assign below_top = count_r - CNT_W'(2);
  assign rd_idx    = below_top[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_idx] <= ctrl.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      top_r <= ctrl.rec;
    end else if (ctrl.pop) begin
      top_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.push) begin
      count_r <= count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  assign count = count_r;
  assign top   = top_r;

endmodule

/* hw/rtl/lifo_arena_allocator.sv */
// lifo_arena_allocator: bump-pointer arena with a lifo record stack
// one op per cycle while the output is not stalled (alloc, free top, grow);
// an input register holds the item with the first step of the alignment
// divide, the ops run in one pass into the result register, and the record
// stack keeps its top entry in a register so that pops can follow each
// other. uses lfa_pkg and lfa_rec_stack
module lifo_arena_allocator #(
  parameter int unsigned ALIGN_BYTES      = 32,
  parameter int unsigned MAX_RECORDS      = 64,
  parameter int unsigned INITIAL_CAPACITY = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // request_size[23:0], block_offset[47:24]
  input  logic [1:0]    in_tuser,   // op[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  // offset[23:0], status[26:24], total_allocated[58:27], peak_allocated[90:59],
  // capacity_now[114:91], zero fill[119:115]
  output logic [119:0]  out_tdata,
  output logic          out_tuser   // from_heap
);

  localparam int unsigned AW    = lfa_pkg::ADDR_W;
  localparam int unsigned TW    = lfa_pkg::TOTAL_W;
  localparam int unsigned RW    = lfa_pkg::REC_SIZE_W;
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int unsigned RECIP = (1 << RW) / ALIGN_BYTES;
  localparam int unsigned PW    = 2 * RW + 1;

  // ---------------- input register ----------------
  logic                 s1_valid_r;
  lfa_pkg::op_t         s1_op_r;
  logic [RW-1:0]        s1_x_r;      // request rounded up by align-1
  logic [RW-1:0]        s1_q_r;      // quotient estimate, low by at most one
  logic [AW-1:0]        s1_given_r;

  logic                 advance;
  logic                 in_xfer;
  logic                 fire;
  logic [RW-1:0]        in_x;
  logic [PW-1:0]        in_prod;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign fire      = s1_valid_r && advance;

  assign in_x    = RW'(in_tdata[23:0]) + RW'(ALIGN_BYTES - 1);
  assign in_prod = PW'(in_x) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r    <= lfa_pkg::op_t'(in_tuser);
      s1_x_r     <= in_x;
      s1_q_r     <= in_prod[2*RW-1:RW];
      s1_given_r <= in_tdata[47:24];
    end
  end

  // ---------------- state ----------------
  logic [AW-1:0]        bump_r, bump_nxt;
  logic [AW-1:0]        cap_r, cap_nxt;
  logic [TW-1:0]        total_r, total_nxt;
  logic [TW-1:0]        hw_r, hw_nxt;

  lfa_pkg::stack_ctrl_t stk_ctrl;
  lfa_pkg::record_t     stk_top;
  logic [CNT_W-1:0]     stk_count;

  lfa_rec_stack #(
    .DEPTH (MAX_RECORDS)
  ) u_rec_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (stk_ctrl),
    .count (stk_count),
    .top   (stk_top)
  );

  // ---------------- single pass ----------------
  logic [RW-1:0]        aligned_est;
  logic [RW-1:0]        align_rem;
  logic [RW-1:0]        aligned;

  assign aligned_est = RW'(s1_q_r * RW'(ALIGN_BYTES));
  assign align_rem   = s1_x_r - aligned_est;
  assign aligned     = (align_rem >= RW'(ALIGN_BYTES)) ?
                       aligned_est + RW'(ALIGN_BYTES) : aligned_est;

  logic [AW-1:0]        res_offset;
  logic                 res_heap;
  lfa_pkg::status_t     res_status;

  always_comb begin
    logic [AW+1:0] fit_sum;
    logic          fits;
    logic [TW:0]   tot_sum;
    logic [AW-1:0] expect_off;
    logic [TW:0]   grown;

    fit_sum    = (AW+2)'(bump_r) + (AW+2)'(aligned);
    fits       = fit_sum <= (AW+2)'(cap_r);
    tot_sum    = (TW+1)'(total_r) + (TW+1)'(aligned);
    expect_off = ((RW)'(bump_r) >= stk_top.size) ?
                 AW'((RW)'(bump_r) - stk_top.size) : '0;
    grown      = (TW+1)'(hw_r) + (TW+1)'(hw_r[TW-1:1]);

    bump_nxt       = bump_r;
    cap_nxt        = cap_r;
    total_nxt      = total_r;
    hw_nxt         = hw_r;
    res_offset     = '0;
    res_heap       = 1'b0;
    res_status     = lfa_pkg::ST_OK;
    stk_ctrl.push  = 1'b0;
    stk_ctrl.pop   = 1'b0;
    stk_ctrl.rec.heap = !fits;
    stk_ctrl.rec.size = aligned;

    case (s1_op_r)
      lfa_pkg::OP_ALLOC: begin
        if (stk_count == CNT_W'(MAX_RECORDS)) begin
          res_status = lfa_pkg::ST_STACK_FULL;
        end else begin
          if (fits) begin
            res_offset = bump_r;
            bump_nxt   = fit_sum[AW-1:0];
          end
          res_heap      = !fits;
          total_nxt     = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
          hw_nxt        = (total_nxt > hw_r) ? total_nxt : hw_r;
          stk_ctrl.push = fire;
        end
      end
      lfa_pkg::OP_FREE: begin
        if (stk_count == '0) begin
          res_status = lfa_pkg::ST_FREE_EMPTY;
        end else if (!stk_top.heap && (expect_off != s1_given_r)) begin
          res_status = lfa_pkg::ST_MISMATCH;
          res_offset = expect_off;
        end else begin
          if (!stk_top.heap) begin
            bump_nxt   = expect_off;
            res_offset = s1_given_r;
          end
          res_heap     = stk_top.heap;
          total_nxt    = (total_r >= TW'(stk_top.size)) ? total_r - TW'(stk_top.size) : '0;
          stk_ctrl.pop = fire;
        end
      end
      lfa_pkg::OP_GROW: begin
        if (total_r != '0) begin
          res_status = lfa_pkg::ST_GROW_IN_USE;
        end else if (hw_r > TW'(cap_r)) begin
          cap_nxt = (grown > (TW+1)'({AW{1'b1}})) ? '1 : grown[AW-1:0];
        end
      end
      default: begin
        // unused opcode, no state change
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r  <= '0;
      cap_r   <= AW'(INITIAL_CAPACITY);
      total_r <= '0;
      hw_r    <= '0;
    end else if (fire) begin
      bump_r  <= bump_nxt;
      cap_r   <= cap_nxt;
      total_r <= total_nxt;
      hw_r    <= hw_nxt;
    end
  end

  // ---------------- result register ----------------
  logic                 out_valid_r;
  logic [AW-1:0]        out_offset_r;
  logic                 out_heap_r;
  lfa_pkg::status_t     out_status_r;
  logic [TW-1:0]        out_total_r;
  logic [TW-1:0]        out_peak_r;
  logic [AW-1:0]        out_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_offset_r <= res_offset;
      out_heap_r   <= res_heap;
      out_status_r <= res_status;
      out_total_r  <= total_nxt;
      out_peak_r   <= hw_nxt;
      out_cap_r    <= cap_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_heap_r;
  assign out_tdata  = {5'b0, out_cap_r, out_peak_r, out_total_r, out_status_r, out_offset_r};

endmodule
